### rtl/core/assert_macros.svh
// assertion macros used by the port checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds in the same cycle as the trigger
`define Q2E_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("check failed: same cycle");

// condition holds in the cycle after the trigger
`define Q2E_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("check failed: next cycle");

`endif

### rtl/core/q2e_pkg.sv
// types, constants and the arctangent table of the quaternion to euler unit
package q2e_pkg;

	localparam int QUAT_FRAC_BITS   = 14;
	localparam int ANGLE_BITS       = 16;
	localparam int DEF_CORDIC_STEPS = 16;
	localparam int QW               = 16;
	// width of the product terms
	localparam int TW               = 34;
	// width of normalized magnitudes
	localparam int NW               = 31;
	// width of cordic x and y
	localparam int CW               = 34;
	// width of the cordic angle, 2^31 = pi
	localparam int ZW               = 32;
	// asin magnitude width, one = 2^30
	localparam int MW               = 31;
	// radicand and square root work width
	localparam int RW               = 62;
	localparam int SQRT_STEPS       = 31;

	typedef struct packed {
		logic signed [QW-1:0] quat_x;
		logic signed [QW-1:0] quat_y;
		logic signed [QW-1:0] quat_z;
		logic signed [QW-1:0] quat_w;
	} quat_t;

	typedef struct packed {
		logic signed [ANGLE_BITS-1:0] angle_first;
		logic signed [ANGLE_BITS-1:0] angle_second;
		logic signed [ANGLE_BITS-1:0] angle_third;
		logic                         asin_clamped;
	} euler_t;

	typedef struct packed {
		logic signed [TW-1:0] a1;
		logic signed [TW-1:0] b1;
		logic signed [TW-1:0] sv;
		logic signed [TW-1:0] a3;
		logic signed [TW-1:0] b3;
	} terms_t;

	// atan(2^-i), 2^31 = pi, rounded to nearest
	function automatic logic [ZW-1:0] arc_tab(input logic [4:0] idx);
		logic [ZW-1:0] r;
		unique case (idx)
			5'd0:  r = 32'h20000000;
			5'd1:  r = 32'h12E4051E;
			5'd2:  r = 32'h09FB385B;
			5'd3:  r = 32'h051111D4;
			5'd4:  r = 32'h028B0D43;
			5'd5:  r = 32'h0145D7E1;
			5'd6:  r = 32'h00A2F61E;
			5'd7:  r = 32'h00517C55;
			5'd8:  r = 32'h0028BE53;
			5'd9:  r = 32'h00145F2F;
			5'd10: r = 32'h000A2F98;
			5'd11: r = 32'h000517CC;
			5'd12: r = 32'h00028BE6;
			5'd13: r = 32'h000145F3;
			5'd14: r = 32'h0000A2FA;
			5'd15: r = 32'h0000517D;
			5'd16: r = 32'h000028BE;
			5'd17: r = 32'h0000145F;
			5'd18: r = 32'h00000A30;
			5'd19: r = 32'h00000518;
			5'd20: r = 32'h0000028C;
			5'd21: r = 32'h00000146;
			5'd22: r = 32'h000000A3;
			5'd23: r = 32'h00000051;
			5'd24: r = 32'h00000029;
			5'd25: r = 32'h00000014;
			5'd26: r = 32'h0000000A;
			5'd27: r = 32'h00000005;
			5'd28: r = 32'h00000003;
			5'd29: r = 32'h00000001;
			5'd30: r = 32'h00000001;
			5'd31: r = 32'h00000000;
		endcase
		return r;
	endfunction

endpackage

### rtl/core/q2e_terms.sv
// products and the five quaternion terms, two pipeline stages
module q2e_terms (
	input  logic             clk,
	input  logic             ce,
	input  q2e_pkg::quat_t   quat,
	output q2e_pkg::terms_t  terms
);

	localparam int TW = q2e_pkg::TW;
	localparam logic signed [TW-1:0] QONE = TW'(64'd1 << (2 * q2e_pkg::QUAT_FRAC_BITS));

	logic signed [2*q2e_pkg::QW-1:0] wz_s1, xy_s1, zx_s1, wy_s1, wx_s1, yz_s1;
	logic signed [2*q2e_pkg::QW-1:0] xx_s1, yy_s1, zz_s1;
	q2e_pkg::terms_t terms_s2;

	// stage 1: all products
	always_ff @(posedge clk) begin
		if (ce) begin
			wz_s1 <= quat.quat_w * quat.quat_z;
			xy_s1 <= quat.quat_x * quat.quat_y;
			zx_s1 <= quat.quat_z * quat.quat_x;
			wy_s1 <= quat.quat_w * quat.quat_y;
			wx_s1 <= quat.quat_w * quat.quat_x;
			yz_s1 <= quat.quat_y * quat.quat_z;
			xx_s1 <= quat.quat_x * quat.quat_x;
			yy_s1 <= quat.quat_y * quat.quat_y;
			zz_s1 <= quat.quat_z * quat.quat_z;
		end
	end

	// stage 2: sums, doubled, one is 2^(2*frac)
	always_ff @(posedge clk) begin
		if (ce) begin
			terms_s2.a1 <= (TW'(wz_s1) + TW'(xy_s1)) <<< 1;
			terms_s2.b1 <= QONE - ((TW'(yy_s1) + TW'(zz_s1)) <<< 1);
			terms_s2.sv <= (TW'(zx_s1) - TW'(wy_s1)) <<< 1;
			terms_s2.a3 <= (TW'(wx_s1) + TW'(yz_s1)) <<< 1;
			terms_s2.b3 <= ((TW'(xx_s1) + TW'(yy_s1)) <<< 1) - QONE;
		end
	end

	assign terms = terms_s2;

endmodule

### rtl/core/q2e_isqrt.sv
// pipelined integer square root, one result bit per stage
module q2e_isqrt (
	input  logic                      clk,
	input  logic                      ce,
	input  logic [q2e_pkg::RW-1:0]    rad,
	output logic [q2e_pkg::MW-1:0]    root
);

	localparam int RW    = q2e_pkg::RW;
	localparam int STEPS = q2e_pkg::SQRT_STEPS;

	logic [RW-1:0] v_s [STEPS+1];
	logic [RW-1:0] r_s [STEPS+1];

	assign v_s[0] = rad;
	assign r_s[0] = '0;

	// restoring digit steps, bit weight 4^(STEPS-1-k)
	for (genvar k = 0; k < STEPS; k++) begin : g_bit
		localparam logic [RW-1:0] BIT = RW'(1) << (2 * (STEPS - 1 - k));
		logic [RW-1:0] trial;
		assign trial = r_s[k] + BIT;
		always_ff @(posedge clk) begin
			if (ce) begin
				if (v_s[k] >= trial) begin
					v_s[k+1] <= v_s[k] - trial;
					r_s[k+1] <= (r_s[k] >> 1) + BIT;
				end else begin
					v_s[k+1] <= v_s[k];
					r_s[k+1] <= r_s[k] >> 1;
				end
			end
		end
	end

	assign root = q2e_pkg::MW'(r_s[STEPS]);

endmodule

### rtl/core/q2e_cordic.sv
// pipelined cordic atan2: normalize, half-plane turn, micro-rotations, rounding
module q2e_cordic #(
	parameter int STEPS = q2e_pkg::DEF_CORDIC_STEPS
) (
	input  logic                               clk,
	input  logic                               ce,
	input  logic signed [q2e_pkg::TW-1:0]      y_in,
	input  logic signed [q2e_pkg::TW-1:0]      x_in,
	output logic [q2e_pkg::ANGLE_BITS-1:0]     angle
);

	localparam int TW = q2e_pkg::TW;
	localparam int NW = q2e_pkg::NW;
	localparam int CW = q2e_pkg::CW;
	localparam int ZW = q2e_pkg::ZW;
	localparam int AB = q2e_pkg::ANGLE_BITS;
	localparam int RS = ZW - AB;
	localparam logic [TW-1:0] TOP1 = TW'(1) << NW;
	localparam logic [TW-1:0] TOP2 = TW'(1) << (NW + 1);
	localparam logic [ZW-1:0] Z_QUARTER     = 32'h4000_0000;
	localparam logic [ZW-1:0] Z_NEG_QUARTER = 32'hC000_0000;
	localparam logic [ZW-1:0] Z_HALF_STEP   = ZW'(1) << (RS - 1);

	logic [TW-1:0] ux_c, uy_c, m_c;
	logic [NW-1:0] ux_n1, uy_n1, ux_n2, uy_n2, ux_n3, uy_n3;
	logic [NW-1:0] ux_a, uy_a, ux_b, uy_b;
	logic          sx_n1, sy_n1, zero_n1, sx_n2, sy_n2, zero_n2, sx_n3, sy_n3, zero_n3;
	logic signed [CW-1:0] xs_c, ys_c, xp_c, yp_c;
	logic [ZW-1:0] zp_c;
	logic signed [CW-1:0] x_s [STEPS+1];
	logic signed [CW-1:0] y_s [STEPS+1];
	logic [ZW-1:0]        z_s [STEPS+1];
	logic                 zero_s [STEPS+1];
	logic [AB-1:0]        angle_sr;

	// magnitudes
	always_comb begin
		ux_c = x_in[TW-1] ? TW'(-x_in) : TW'(x_in);
		uy_c = y_in[TW-1] ? TW'(-y_in) : TW'(y_in);
		m_c  = ux_c | uy_c;
	end

	// normalize stage 1: right shift below 2^31, truncating
	always_ff @(posedge clk) begin
		if (ce) begin
			priority if (m_c >= TOP2) begin
				ux_n1 <= NW'(ux_c >> 2);
				uy_n1 <= NW'(uy_c >> 2);
			end else if (m_c >= TOP1) begin
				ux_n1 <= NW'(ux_c >> 1);
				uy_n1 <= NW'(uy_c >> 1);
			end else begin
				ux_n1 <= NW'(ux_c);
				uy_n1 <= NW'(uy_c);
			end
			sx_n1   <= x_in[TW-1];
			sy_n1   <= y_in[TW-1];
			zero_n1 <= (m_c == '0);
		end
	end

	// normalize stage 2: left by 16 and 8
	always_comb begin
		ux_a = ux_n1;
		uy_a = uy_n1;
		if ((ux_a | uy_a) < (NW'(1) << (NW - 16))) begin
			ux_a = ux_a << 16;
			uy_a = uy_a << 16;
		end
		if ((ux_a | uy_a) < (NW'(1) << (NW - 8))) begin
			ux_a = ux_a << 8;
			uy_a = uy_a << 8;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			ux_n2   <= ux_a;
			uy_n2   <= uy_a;
			sx_n2   <= sx_n1;
			sy_n2   <= sy_n1;
			zero_n2 <= zero_n1;
		end
	end

	// normalize stage 3: left by 4, 2 and 1
	always_comb begin
		ux_b = ux_n2;
		uy_b = uy_n2;
		if ((ux_b | uy_b) < (NW'(1) << (NW - 4))) begin
			ux_b = ux_b << 4;
			uy_b = uy_b << 4;
		end
		if ((ux_b | uy_b) < (NW'(1) << (NW - 2))) begin
			ux_b = ux_b << 2;
			uy_b = uy_b << 2;
		end
		if ((ux_b | uy_b) < (NW'(1) << (NW - 1))) begin
			ux_b = ux_b << 1;
			uy_b = uy_b << 1;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			ux_n3   <= ux_b;
			uy_n3   <= uy_b;
			sx_n3   <= sx_n2;
			sy_n3   <= sy_n2;
			zero_n3 <= zero_n2;
		end
	end

	// signs back, left half-plane turned by a quarter
	always_comb begin
		xs_c = CW'(signed'({1'b0, ux_n3}));
		ys_c = CW'(signed'({1'b0, uy_n3}));
		if (sx_n3) xs_c = -xs_c;
		if (sy_n3) ys_c = -ys_c;
		xp_c = xs_c;
		yp_c = ys_c;
		zp_c = '0;
		if (xs_c[CW-1]) begin
			if (!ys_c[CW-1]) begin
				xp_c = ys_c;
				yp_c = -xs_c;
				zp_c = Z_QUARTER;
			end else begin
				xp_c = -ys_c;
				yp_c = xs_c;
				zp_c = Z_NEG_QUARTER;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			x_s[0]    <= xp_c;
			y_s[0]    <= yp_c;
			z_s[0]    <= zp_c;
			zero_s[0] <= zero_n3;
		end
	end

	// micro-rotations, one per stage
	for (genvar i = 0; i < STEPS; i++) begin : g_step
		always_ff @(posedge clk) begin
			if (ce) begin
				if (!y_s[i][CW-1]) begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + q2e_pkg::arc_tab(5'(i));
				end else begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - q2e_pkg::arc_tab(5'(i));
				end
				zero_s[i+1] <= zero_s[i];
			end
		end
	end

	// round half up to the output angle width
	always_ff @(posedge clk) begin
		if (ce) begin
			angle_sr <= zero_s[STEPS] ? '0 : AB'((z_s[STEPS] + Z_HALF_STEP) >> RS);
		end
	end

	assign angle = angle_sr;

endmodule

### rtl/core/quaternion_to_euler_unit.sv
// quaternion to euler angles, top level
//
//   channel  payload   handshake                  direction
//   quat     quat_t    quat_valid / quat_ready    in
//   euler    euler_t   euler_valid / euler_ready  out
//
// one transaction per cycle while the output is not stalled; latency is set by the
// 31-stage square root of the asin lane followed by the cordic pipeline
// every stage advances together when the output register is empty or taken
// a stalled output holds the whole pipeline and drops quat_ready
// reset clears the valid bits only; the data path carries no reset
module quaternion_to_euler_unit #(
	parameter int CORDIC_STEPS = q2e_pkg::DEF_CORDIC_STEPS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  q2e_pkg::quat_t    quat,
	input  logic              quat_valid,
	output logic              quat_ready,
	output q2e_pkg::euler_t   euler,
	output logic              euler_valid,
	input  logic              euler_ready
);

	localparam int TW   = q2e_pkg::TW;
	localparam int MW   = q2e_pkg::MW;
	localparam int RW   = q2e_pkg::RW;
	localparam int AB   = q2e_pkg::ANGLE_BITS;
	localparam int SQN  = q2e_pkg::SQRT_STEPS;
	localparam int CLAT = CORDIC_STEPS + 5;
	localparam int DT   = 2 + SQN;
	localparam int DF   = SQN + CLAT;
	localparam int LAT  = 4 + SQN + CLAT + 1;
	localparam int MSH  = 30 - 2 * q2e_pkg::QUAT_FRAC_BITS;
	localparam logic [TW-1:0] QONE    = TW'(64'd1 << (2 * q2e_pkg::QUAT_FRAC_BITS));
	localparam logic [RW-1:0] RAD_ONE = RW'(1) << (2 * (MW - 1));

	logic                ce;
	logic [LAT-1:0]      vld_q;
	q2e_pkg::terms_t     terms;
	logic [TW-1:0]       mag_c;
	logic                clamp_c;
	logic [MW-1:0]       m_s3, m_s4;
	logic                neg_s3, neg_s4, clamp_s3, clamp_s4;
	logic [RW-1:0]       rad_s4;
	logic [MW-1:0]       root;
	q2e_pkg::terms_t     terms_d [DT];
	logic [MW-1:0]       m_d [SQN];
	logic [1:0]          flag_d [DF];
	logic [AB-1:0]       ang1, ang2, ang3;
	q2e_pkg::euler_t     euler_sr;

	// global advance: output empty or being taken
	assign ce         = !vld_q[LAT-1] || euler_ready;
	assign quat_ready = ce;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (ce) begin
			vld_q <= {vld_q[LAT-2:0], quat_valid};
		end
	end

	q2e_terms u_terms (
		.clk   (clk),
		.ce    (ce),
		.quat  (quat),
		.terms (terms)
	);

	// asin argument magnitude, saturated to one
	always_comb begin
		mag_c   = terms.sv[TW-1] ? TW'(-terms.sv) : TW'(terms.sv);
		clamp_c = mag_c > QONE;
		if (clamp_c) mag_c = QONE;
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			m_s3     <= MW'(mag_c) << MSH;
			neg_s3   <= terms.sv[TW-1];
			clamp_s3 <= clamp_c;
		end
	end

	// radicand 1 - m^2 with one = 2^60
	always_ff @(posedge clk) begin
		if (ce) begin
			rad_s4   <= RAD_ONE - (RW'(m_s3) * RW'(m_s3));
			m_s4     <= m_s3;
			neg_s4   <= neg_s3;
			clamp_s4 <= clamp_s3;
		end
	end

	q2e_isqrt u_isqrt (
		.clk  (clk),
		.ce   (ce),
		.rad  (rad_s4),
		.root (root)
	);

	// alignment delays for terms, asin magnitude and sign/clamp flags
	always_ff @(posedge clk) begin
		if (ce) begin
			terms_d[0] <= terms;
			for (int k = 1; k < DT; k++) terms_d[k] <= terms_d[k-1];
			m_d[0] <= m_s4;
			for (int k = 1; k < SQN; k++) m_d[k] <= m_d[k-1];
			flag_d[0] <= {neg_s4, clamp_s4};
			for (int k = 1; k < DF; k++) flag_d[k] <= flag_d[k-1];
		end
	end

	q2e_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_first (
		.clk   (clk),
		.ce    (ce),
		.y_in  (terms_d[DT-1].a1),
		.x_in  (terms_d[DT-1].b1),
		.angle (ang1)
	);

	q2e_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_second (
		.clk   (clk),
		.ce    (ce),
		.y_in  (signed'(TW'(m_d[SQN-1]))),
		.x_in  (signed'(TW'(root))),
		.angle (ang2)
	);

	q2e_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_third (
		.clk   (clk),
		.ce    (ce),
		.y_in  (terms_d[DT-1].a3),
		.x_in  (terms_d[DT-1].b3),
		.angle (ang3)
	);

	// output register, asin sign applied
	always_ff @(posedge clk) begin
		if (ce) begin
			euler_sr.angle_first  <= ang1;
			euler_sr.angle_second <= flag_d[DF-1][1] ? AB'(-ang2) : ang2;
			euler_sr.angle_third  <= ang3;
			euler_sr.asin_clamped <= flag_d[DF-1][0];
		end
	end

	assign euler       = euler_sr;
	assign euler_valid = vld_q[LAT-1];

endmodule

### rtl/core/q2e_checker.sv
// port checker for the quaternion to euler unit and its bind
`include "assert_macros.svh"

module q2e_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            quat_ready,
	input q2e_pkg::euler_t euler,
	input logic            euler_valid,
	input logic            euler_ready
);

	// a waiting result holds its value
	`Q2E_ASSERT_NEXT(a_out_hold, euler_valid && !euler_ready, euler_valid && $stable(euler))

	// an empty output never blocks the input side
	`Q2E_ASSERT_NOW(a_ready_when_empty, !euler_valid, quat_ready)

	// a stalled result freezes the pipeline
	`Q2E_ASSERT_NOW(a_stall_blocks, euler_valid && !euler_ready, !quat_ready)

endmodule

bind quaternion_to_euler_unit q2e_checker u_q2e_checker (.*);
